FILE: rtl/core/mcor_pkg.sv
// ----------------------------------------------------------------------------
// mcor_pkg: shared types for the midpoint circle outline raster core
// Item, queue entry, configuration and result types, codes and the octant
// ordering used when points are expanded.
// ----------------------------------------------------------------------------
package mcor_pkg;

  // default point coordinate width
  localparam int unsigned COORD_BITS_DEF = 16;
  // depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  // points per iteration step
  localparam int unsigned NUM_OCTANTS = 8;

  // input item kinds
  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_SCREEN_WIDTH  = 3'd0,
    CFG_SCREEN_HEIGHT = 3'd1,
    CFG_AREA_LEFT     = 3'd2,
    CFG_AREA_RIGHT    = 3'd3,
    CFG_AREA_TOP      = 3'd4,
    CFG_AREA_BOTTOM   = 3'd5,
    CFG_ORIENTATION   = 3'd6
  } cfg_idx_e;

  // display orientation codes
  typedef enum logic [1:0] {
    ORIENT_NORMAL       = 2'd0,
    ORIENT_ROTATE_LEFT  = 2'd1,
    ORIENT_ROTATE_RIGHT = 2'd2,
    ORIENT_UPSIDE_DOWN  = 2'd3
  } orient_e;

  // configuration register set
  typedef struct packed {
    logic [14:0] screen_width;
    logic [14:0] screen_height;
    logic [15:0] area_left;
    logic [15:0] area_right;
    logic [15:0] area_top;
    logic [15:0] area_bottom;
    orient_e     orientation;
  } cfg_t;

  // one accepted input item
  typedef struct packed {
    op_e         op;
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic [14:0] radius;
    logic [15:0] color;
  } in_item_t;

  // work handed from front to back: either eight points or the finished marker
  typedef struct packed {
    logic        finished;
    logic [15:0] cx;
    logic [15:0] cy;
    logic [15:0] ox;
    logic [15:0] oy;
    logic [15:0] color;
  } job_t;

  // one result item
  typedef struct packed {
    logic        visible;
    logic [15:0] panel_x;
    logic [15:0] panel_y;
    logic [15:0] pixel_color;
    logic        last;
    logic        finished;
  } result_t;

  // octant point shape: swap offsets, negate x term, negate y term
  typedef struct packed {
    logic swap;
    logic neg_x;
    logic neg_y;
  } octant_t;

  // octant order: (+x,+y) (+y,+x) (-y,+x) (-x,+y) (-x,-y) (-y,-x) (+y,-x) (+x,-y)
  function automatic octant_t octant_shape(logic [2:0] k);
    octant_t s;
    case (k)
      3'd0:    s = '{swap: 1'b0, neg_x: 1'b0, neg_y: 1'b0};
      3'd1:    s = '{swap: 1'b1, neg_x: 1'b0, neg_y: 1'b0};
      3'd2:    s = '{swap: 1'b1, neg_x: 1'b1, neg_y: 1'b0};
      3'd3:    s = '{swap: 1'b0, neg_x: 1'b1, neg_y: 1'b0};
      3'd4:    s = '{swap: 1'b0, neg_x: 1'b1, neg_y: 1'b1};
      3'd5:    s = '{swap: 1'b1, neg_x: 1'b1, neg_y: 1'b1};
      3'd6:    s = '{swap: 1'b1, neg_x: 1'b0, neg_y: 1'b1};
      default: s = '{swap: 1'b0, neg_x: 1'b0, neg_y: 1'b1};
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/core/mcor_front.sv
// ----------------------------------------------------------------------------
// mcor_front: item intake and midpoint iteration
// Takes start and step items, keeps the circle state, advances the midpoint
// iteration once per step and queues a job for the point expander.
// ----------------------------------------------------------------------------
module mcor_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mcor_pkg::in_item_t in_item_i,
  input  logic              queue_full_i,
  output logic              push_o,
  output mcor_pkg::job_t    job_o
);

  logic [15:0] cx_q, cx_d, cy_q, cy_d;
  logic [15:0] x_q, x_d, y_q, y_d, e_q, e_d;
  logic [15:0] color_q, color_d;
  logic        active_q, active_d;

  logic        accept;
  logic        is_step;
  logic        done_now;
  logic [15:0] y1, e1, x1, e2, x_n, e_n;
  logic [16:0] diff;
  logic        dec_x;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_step    = (in_item_i.op == mcor_pkg::OP_STEP);
  assign done_now   = !active_q || ($signed(x_q) < $signed(y_q));

  // one midpoint update, all 16 bit wrapping
  always_comb begin
    y1    = y_q + 16'd1;
    e1    = e_q + 16'd1 + {y1[14:0], 1'b0};
    diff  = {e1[15], e1} - {x_q[15], x_q};
    // 2*(e-x)+1 > 0 exactly when e-x >= 0
    dec_x = !diff[16];
    x1    = x_q - 16'd1;
    e2    = e1 + 16'd1 - {x1[14:0], 1'b0};
    x_n   = dec_x ? x1 : x_q;
    e_n   = dec_x ? e2 : e1;
  end

  // next circle state
  always_comb begin
    cx_d     = cx_q;
    cy_d     = cy_q;
    x_d      = x_q;
    y_d      = y_q;
    e_d      = e_q;
    color_d  = color_q;
    active_d = active_q;
    if (accept) begin
      if (!is_step) begin
        cx_d     = in_item_i.center_x;
        cy_d     = in_item_i.center_y;
        x_d      = {1'b0, in_item_i.radius};
        y_d      = '0;
        e_d      = '0;
        color_d  = in_item_i.color;
        active_d = 1'b1;
      end else if (done_now) begin
        active_d = 1'b0;
      end else begin
        x_d      = x_n;
        y_d      = y1;
        e_d      = e_n;
        active_d = !($signed(x_n) < $signed(y1));
      end
    end
  end

  // job for the back end
  assign push_o         = accept && is_step;
  assign job_o.finished = done_now;
  assign job_o.cx       = cx_q;
  assign job_o.cy       = cy_q;
  assign job_o.ox       = x_q;
  assign job_o.oy       = y_q;
  assign job_o.color    = color_q;

  // circle state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q     <= '0;
      cy_q     <= '0;
      x_q      <= '0;
      y_q      <= '0;
      e_q      <= '0;
      color_q  <= '0;
      active_q <= 1'b0;
    end else begin
      cx_q     <= cx_d;
      cy_q     <= cy_d;
      x_q      <= x_d;
      y_q      <= y_d;
      e_q      <= e_d;
      color_q  <= color_d;
      active_q <= active_d;
    end
  end

endmodule

FILE: rtl/core/mcor_queue.sv
// ----------------------------------------------------------------------------
// mcor_queue: job queue between front and back
// Small first-in first-out buffer so that intake and point expansion stall
// independently.
// ----------------------------------------------------------------------------
module mcor_queue #(
  parameter int unsigned Depth = mcor_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mcor_pkg::job_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output mcor_pkg::job_t pop_data_o,
  output logic           empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  mcor_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o     = (count_q == CntW'(Depth));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !pop_i |-> !push_i)
    else $error("queue written while full");
  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("queue read while empty");
`endif

endmodule

FILE: rtl/core/mcor_back.sv
// ----------------------------------------------------------------------------
// mcor_back: point expander, clipping and orientation mapping
// Turns each job into its eight octant points, or one finished result,
// one per cycle unless the output stalls; clips them against screen and
// draw area, maps them to panel addresses and holds the result in an
// output register.
module mcor_back #(
  parameter int unsigned CoordBits = mcor_pkg::COORD_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mcor_pkg::cfg_t    cfg_i,
  input  logic              queue_empty_i,
  input  mcor_pkg::job_t    job_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mcor_pkg::result_t out_o
);

  mcor_pkg::job_t    cur_q;
  logic              cur_valid_q, cur_valid_d;
  logic [2:0]        k_q, k_d;
  mcor_pkg::result_t res_q, res_d;
  logic              res_valid_q, res_valid_d;

  logic              advance;
  logic              cur_last;
  mcor_pkg::octant_t shape;
  logic [15:0]       off_a, off_b, sum_x, sum_y;
  logic [CoordBits-1:0] px, py, map_x, map_y;
  logic signed [16:0] pxe, pye;
  logic              vis;
  logic [15:0]       w_minus_x, w_minus_y, h_minus_x, h_minus_y;

  assign advance  = !res_valid_q || out_ready_i;
  assign cur_last = cur_q.finished || (k_q == 3'(mcor_pkg::NUM_OCTANTS - 1));
  assign pop_o    = !queue_empty_i && (!cur_valid_q || (advance && cur_last));

  // octant point coordinates, wrapped to the coordinate width
  always_comb begin
    shape = mcor_pkg::octant_shape(k_q);
    off_a = shape.swap ? cur_q.oy : cur_q.ox;
    off_b = shape.swap ? cur_q.ox : cur_q.oy;
    sum_x = shape.neg_x ? cur_q.cx - off_a : cur_q.cx + off_a;
    sum_y = shape.neg_y ? cur_q.cy - off_b : cur_q.cy + off_b;
    px    = sum_x[CoordBits-1:0];
    py    = sum_y[CoordBits-1:0];
    pxe   = 17'($signed(px));
    pye   = 17'($signed(py));
  end

  // screen and draw area clipping
  always_comb begin
    vis = 1'b1;
    if (pxe > $signed({2'b00, cfg_i.screen_width}) ||
        pxe < 17'($signed(cfg_i.area_left)) ||
        pxe > 17'($signed(cfg_i.area_right))) begin
      vis = 1'b0;
    end
    if (pye > $signed({2'b00, cfg_i.screen_height}) ||
        pye < 17'($signed(cfg_i.area_top)) ||
        pye > 17'($signed(cfg_i.area_bottom))) begin
      vis = 1'b0;
    end
  end

  // orientation mapping, modulo the coordinate width
  always_comb begin
    w_minus_x = {1'b0, cfg_i.screen_width} - 16'($signed(px));
    w_minus_y = {1'b0, cfg_i.screen_width} - 16'($signed(py));
    h_minus_x = {1'b0, cfg_i.screen_height} - 16'($signed(px));
    h_minus_y = {1'b0, cfg_i.screen_height} - 16'($signed(py));
    case (cfg_i.orientation)
      mcor_pkg::ORIENT_ROTATE_LEFT: begin
        map_x = py;
        map_y = h_minus_x[CoordBits-1:0];
      end
      mcor_pkg::ORIENT_ROTATE_RIGHT: begin
        map_x = w_minus_y[CoordBits-1:0];
        map_y = px;
      end
      mcor_pkg::ORIENT_UPSIDE_DOWN: begin
        map_x = w_minus_x[CoordBits-1:0];
        map_y = h_minus_y[CoordBits-1:0];
      end
      default: begin
        map_x = px;
        map_y = py;
      end
    endcase
  end

  // next result and sequencing
  always_comb begin
    res_d       = res_q;
    res_valid_d = res_valid_q;
    cur_valid_d = cur_valid_q;
    k_d         = k_q;
    if (advance) begin
      res_valid_d = cur_valid_q;
      if (cur_valid_q) begin
        if (cur_q.finished) begin
          res_d = '{visible: 1'b0, panel_x: '0, panel_y: '0, pixel_color: '0,
                    last: 1'b1, finished: 1'b1};
        end else begin
          res_d = '{visible: vis, panel_x: 16'(map_x), panel_y: 16'(map_y),
                    pixel_color: cur_q.color, last: cur_last, finished: 1'b0};
        end
        if (cur_last) begin
          cur_valid_d = 1'b0;
          k_d         = '0;
        end else begin
          k_d = k_q + 3'd1;
        end
      end
    end
    if (pop_o) begin
      cur_valid_d = 1'b1;
      k_d         = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      k_q         <= '0;
      res_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      k_q         <= k_d;
      res_valid_q <= res_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (pop_o) begin
      cur_q <= job_i;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_o       = res_q;

`ifndef SYNTHESIS
  a_idle_count_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cur_valid_q |-> (k_q == 3'd0))
    else $error("octant counter running without a job");
  a_finished_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.finished |-> res_q.last && !res_q.visible)
    else $error("finished result not marked last");
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !out_ready_i |=> res_valid_q && $stable(res_q))
    else $error("stalled result changed");
`endif

endmodule

FILE: rtl/core/midpoint_circle_outline_raster_core.sv
// ----------------------------------------------------------------------------
// midpoint_circle_outline_raster_core: midpoint circle outline rasteriser
// Top level: configuration registers, item intake, job queue and point
// expander.
// ----------------------------------------------------------------------------
// Usage
//   s_axis carries items: tuser is the kind (start or step); a start loads
//   centre, radius and colour and produces nothing, a step produces eight
//   octant points, or one finished result once the circle is complete or
//   when no circle was started.
//   m_axis carries points: tlast marks the final result of a step, tuser
//   holds the visible and finished flags.
//   cfg writes (always ready) set screen size, draw area and orientation;
//   write them only while no work is in flight.
// Timing
//   a step's first point passes the job queue and current-job register to
//   the output register, then one point per cycle unless the output stalls,
//   eight per step from the single point expander; a finished job gives one
//   result. The queue holds two steps, so intake runs while points drain.
// Reset
//   clears configuration to zero and drops any circle in progress.
// Stalls
//   while m_axis_tready is low the held result stays stable; once the queue
//   fills, s_axis_tready drops until the expander frees an entry.
// ----------------------------------------------------------------------------
module midpoint_circle_outline_raster_core #(
  parameter int unsigned COORD_BITS = mcor_pkg::COORD_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] center_x, [31:16] center_y, [46:32] radius, [62:47] color
  input  logic [63:0] s_axis_tdata,
  // [0] op
  input  logic        s_axis_tuser,
  // result points
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] panel_x, [31:16] panel_y, [47:32] pixel_color
  output logic [47:0] m_axis_tdata,
  // [0] visible, [1] finished
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  mcor_pkg::cfg_t    cfg_q;
  mcor_pkg::in_item_t item;
  mcor_pkg::job_t    push_job, pop_job;
  mcor_pkg::result_t res;
  logic              push, pop, q_full, q_empty;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{screen_width: '0, screen_height: '0, area_left: '0,
                 area_right: '0, area_top: '0, area_bottom: '0,
                 orientation: mcor_pkg::ORIENT_NORMAL};
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (mcor_pkg::cfg_idx_e'(cfg_index_i))
        mcor_pkg::CFG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data_i[14:0];
        mcor_pkg::CFG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data_i[14:0];
        mcor_pkg::CFG_AREA_LEFT:     cfg_q.area_left     <= cfg_data_i;
        mcor_pkg::CFG_AREA_RIGHT:    cfg_q.area_right    <= cfg_data_i;
        mcor_pkg::CFG_AREA_TOP:      cfg_q.area_top      <= cfg_data_i;
        mcor_pkg::CFG_AREA_BOTTOM:   cfg_q.area_bottom   <= cfg_data_i;
        mcor_pkg::CFG_ORIENTATION:
          cfg_q.orientation <= mcor_pkg::orient_e'(cfg_data_i[1:0]);
        default: ;
      endcase
    end
  end

  // unpack the input item
  assign item.op       = mcor_pkg::op_e'(s_axis_tuser);
  assign item.center_x = s_axis_tdata[15:0];
  assign item.center_y = s_axis_tdata[31:16];
  assign item.radius   = s_axis_tdata[46:32];
  assign item.color    = s_axis_tdata[62:47];

  mcor_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_item_i    (item),
    .queue_full_i (q_full),
    .push_o       (push),
    .job_o        (push_job)
  );

  mcor_queue #(
    .Depth (mcor_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (q_full),
    .pop_i       (pop),
    .pop_data_o  (pop_job),
    .empty_o     (q_empty)
  );

  mcor_back #(
    .CoordBits (COORD_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .queue_empty_i (q_empty),
    .job_i         (pop_job),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_o         (res)
  );

  // pack the result
  assign m_axis_tdata = {res.pixel_color, res.panel_y, res.panel_x};
  assign m_axis_tuser = {res.finished, res.visible};
  assign m_axis_tlast = res.last;

endmodule

FILE: bench/midpoint_circle_outline_raster_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_circle_outline_raster_core_test: self-checking bench for the core
// Streams start and step items into the rasteriser, predicts every octant
// point (clipping, orientation mapping, finished markers) and compares each
// result transaction in order, under random bursts, gaps and output stalls.
// ----------------------------------------------------------------------------

// outline predictor and store of points still to arrive
class outline_tracker;
  int      scr_w, scr_h;
  int      area_l, area_r, area_t, area_b;
  mcor_pkg::orient_e orient;

  logic signed [15:0] cx, cy, off_x, off_y, err;
  logic [15:0]        col;
  bit                 busy;

  mcor_pkg::result_t pending_points[$];
  int      mismatches;

  function new();
    scr_w = 0; scr_h = 0;
    area_l = 0; area_r = 0; area_t = 0; area_b = 0;
    orient = mcor_pkg::ORIENT_NORMAL;
    cx = '0; cy = '0; off_x = '0; off_y = '0; err = '0; col = '0;
    busy = 1'b0;
    mismatches = 0;
  endfunction

  function int wrap16(int v);
    logic signed [15:0] t;
    t = v[15:0];
    return int'(t);
  endfunction

  function int pending();
    return pending_points.size();
  endfunction

  function void write_reg(mcor_pkg::cfg_idx_e idx, logic [15:0] v);
    case (idx)
      mcor_pkg::CFG_SCREEN_WIDTH:  scr_w = int'(v[14:0]);
      mcor_pkg::CFG_SCREEN_HEIGHT: scr_h = int'(v[14:0]);
      mcor_pkg::CFG_AREA_LEFT:     area_l = wrap16(int'(v));
      mcor_pkg::CFG_AREA_RIGHT:    area_r = wrap16(int'(v));
      mcor_pkg::CFG_AREA_TOP:      area_t = wrap16(int'(v));
      mcor_pkg::CFG_AREA_BOTTOM:   area_b = wrap16(int'(v));
      mcor_pkg::CFG_ORIENTATION:   orient = mcor_pkg::orient_e'(v[1:0]);
      default: ;
    endcase
  endfunction

  // clip one point and map it to panel coordinates
  function mcor_pkg::result_t plot(int px, int py, bit is_last);
    int      x, y;
    mcor_pkg::result_t r;
    x = wrap16(px);
    y = wrap16(py);
    r.visible = !(x > scr_w || x < area_l || x > area_r ||
                  y > scr_h || y < area_t || y > area_b);
    case (orient)
      mcor_pkg::ORIENT_ROTATE_LEFT: begin
        r.panel_x = 16'(y);
        r.panel_y = 16'(scr_h - x);
      end
      mcor_pkg::ORIENT_ROTATE_RIGHT: begin
        r.panel_x = 16'(scr_w - y);
        r.panel_y = 16'(x);
      end
      mcor_pkg::ORIENT_UPSIDE_DOWN: begin
        r.panel_x = 16'(scr_w - x);
        r.panel_y = 16'(scr_h - y);
      end
      default: begin
        r.panel_x = 16'(x);
        r.panel_y = 16'(y);
      end
    endcase
    r.pixel_color = col;
    r.last        = is_last;
    r.finished    = 1'b0;
    return r;
  endfunction

  // one accepted input transaction
  function void take_item(mcor_pkg::in_item_t it);
    int      x, y, e, ccx, ccy;
    mcor_pkg::result_t done;
    if (it.op == mcor_pkg::OP_START) begin
      cx    = it.center_x;
      cy    = it.center_y;
      off_x = {1'b0, it.radius};
      off_y = '0;
      err   = '0;
      col   = it.color;
      busy  = 1'b1;
      return;
    end
    x = int'(off_x);
    y = int'(off_y);
    // no circle in progress or circle complete: single finished marker
    if (!busy || x < y) begin
      busy = 1'b0;
      done = '0;
      done.last     = 1'b1;
      done.finished = 1'b1;
      pending_points.push_back(done);
      return;
    end
    ccx = int'(cx);
    ccy = int'(cy);
    pending_points.push_back(plot(ccx + x, ccy + y, 1'b0));
    pending_points.push_back(plot(ccx + y, ccy + x, 1'b0));
    pending_points.push_back(plot(ccx - y, ccy + x, 1'b0));
    pending_points.push_back(plot(ccx - x, ccy + y, 1'b0));
    pending_points.push_back(plot(ccx - x, ccy - y, 1'b0));
    pending_points.push_back(plot(ccx - y, ccy - x, 1'b0));
    pending_points.push_back(plot(ccx + y, ccy - x, 1'b0));
    pending_points.push_back(plot(ccx + x, ccy - y, 1'b1));
    // advance the midpoint iteration
    e = int'(err);
    y = wrap16(y + 1);
    e = wrap16(e + 1 + 2 * y);
    if (2 * (e - x) + 1 > 0) begin
      x = wrap16(x - 1);
      e = wrap16(e + 1 - 2 * x);
    end
    off_x = x[15:0];
    off_y = y[15:0];
    err   = e[15:0];
    if (x < y) busy = 1'b0;
  endfunction

  function void compare_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // one accepted result transaction
  function void check_point(logic [47:0] data, logic [1:0] user, logic last);
    mcor_pkg::result_t want;
    if (pending_points.size() == 0) begin
      $error("result: expected none, got panel 0x%0h", data);
      mismatches++;
      return;
    end
    want = pending_points.pop_front();
    compare_field("visible", int'(want.visible), int'(user[0]));
    compare_field("panel_x", int'(want.panel_x), int'(data[15:0]));
    compare_field("panel_y", int'(want.panel_y), int'(data[31:16]));
    compare_field("pixel_color", int'(want.pixel_color), int'(data[47:32]));
    compare_field("last", int'(want.last), int'(last));
    compare_field("finished", int'(want.finished), int'(user[1]));
  endfunction
endclass

module midpoint_circle_outline_raster_core_test;

  localparam int RANDOM_ITEMS  = 200;
  localparam int PHASE_ITEMS   = 40;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_AFTER    = 120;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 250000;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i   = '0;
  logic [15:0] cfg_data_i    = '0;

  outline_tracker outline = new();

  int items_sent  = 0;
  int burst_left  = 0;
  int points_seen = 0;
  int cycle_count = 0;

  midpoint_circle_outline_raster_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("midpoint_circle_outline_raster_core_test: FAIL");
      $finish;
    end
  end

  // observe every transaction on the three channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        outline.write_reg(mcor_pkg::cfg_idx_e'(cfg_index_i), cfg_data_i);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        outline.take_item('{op: mcor_pkg::op_e'(s_axis_tuser),
                            center_x: s_axis_tdata[15:0],
                            center_y: s_axis_tdata[31:16], radius: s_axis_tdata[46:32],
                            color: s_axis_tdata[62:47]});
      end
      if (m_axis_tvalid && m_axis_tready) begin
        outline.check_point(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        points_seen++;
      end
    end
  end

  // output back-pressure: changing stall patterns plus one long hold-off
  initial begin
    int  recv_tick;
    int  stall_mode;
    int  hold_left;
    bit  hold_done;
    recv_tick  = 0;
    stall_mode = 0;
    hold_left  = 0;
    hold_done  = 1'b0;
    forever begin
      @(posedge clk_i);
      recv_tick++;
      if (recv_tick % 48 == 0) stall_mode = $urandom_range(0, 3);
      if (!hold_done && points_seen >= HOLD_AFTER) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (stall_mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
          2:       m_axis_tready <= ($urandom_range(0, 1) != 0);
          default: m_axis_tready <= (recv_tick % 5 == 0);
        endcase
      end
    end
  end

  // one input transaction, with random gaps between bursts
  task automatic offer_item(input mcor_pkg::op_e op, input logic [15:0] px,
                            input logic [15:0] py, input logic [14:0] rad,
                            input logic [15:0] colour);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, colour, rad, py, px};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic send_start(input int px, input int py, input int rad, input int colour);
    offer_item(mcor_pkg::OP_START, 16'(px), 16'(py), 15'(rad), 16'(colour));
  endtask

  // step fields are don't-care, so fill them with noise
  task automatic send_steps(input int count);
    repeat (count) begin
      offer_item(mcor_pkg::OP_STEP, 16'($urandom), 16'($urandom), 15'($urandom),
                 16'($urandom));
    end
  endtask

  task automatic write_reg(input mcor_pkg::cfg_idx_e idx, input int value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= 16'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic load_setup(input int w, input int h, input int l, input int r,
                            input int t, input int b, input mcor_pkg::orient_e o);
    write_reg(mcor_pkg::CFG_SCREEN_WIDTH, w);
    write_reg(mcor_pkg::CFG_SCREEN_HEIGHT, h);
    write_reg(mcor_pkg::CFG_AREA_LEFT, l);
    write_reg(mcor_pkg::CFG_AREA_RIGHT, r);
    write_reg(mcor_pkg::CFG_AREA_TOP, t);
    write_reg(mcor_pkg::CFG_AREA_BOTTOM, b);
    write_reg(mcor_pkg::CFG_ORIENTATION, int'(o));
    cfg_valid_i <= 1'b0;
  endtask

  // wait for every predicted point, then let a start item settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    // the last accepted item is noted by the monitor at that same edge
    @(posedge clk_i);
    while (outline.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // mostly whole circles, some cut short, a little noise
  task automatic random_circle();
    int kind, px, py, rad, steps;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      if ($urandom_range(0, 1) != 0) send_steps(1);
      else send_start($urandom, $urandom, $urandom_range(0, 32767), $urandom);
      return;
    end
    if ($urandom_range(0, 3) != 0) begin
      px = $urandom_range(0, 180) - 30;
      py = $urandom_range(0, 180) - 30;
    end else begin
      px = $urandom;
      py = $urandom;
    end
    if ($urandom_range(0, 6) != 0) begin
      rad   = $urandom_range(0, 12);
      steps = rad * 3 / 4 + 2 + $urandom_range(0, 1);
    end else begin
      rad   = $urandom_range(0, 32767);
      steps = $urandom_range(1, 3);
    end
    if (kind == 1) steps = $urandom_range(0, steps - 1);
    send_start(px, py, rad, $urandom);
    send_steps(steps);
  endtask

  function automatic int pick_width();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 32767;
      default: return $urandom_range(20, 150);
    endcase
  endfunction

  // stimulus
  initial begin
    int phase, phase_end, stop_at;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: only the origin is visible
    send_steps(1);
    send_start(0, 0, 0, 16'hFFFF);
    send_steps(3);
    drain();

    // whole coordinate space visible, wrapping and abandoned circles
    load_setup(32767, 32767, -32768, 32767, -32768, 32767, mcor_pkg::ORIENT_NORMAL);
    send_start(32767, -32768, 32767, 16'hAAAA);
    send_steps(3);
    send_start(-32768, 32767, 1, 16'h5555);
    send_steps(2);
    send_start(10, 10, 5, 16'h0000);
    send_steps(5);
    send_start(-3, 200, 3, 16'h1234);
    send_steps(4);
    drain();

    // random phases, each with its own clipping and orientation
    stop_at = items_sent + RANDOM_ITEMS;
    phase   = 0;
    while (items_sent < stop_at) begin
      if (phase == 3)
        load_setup(32767, 0, 32767, -32768, 32767, -32768,
                   mcor_pkg::orient_e'(phase % 4));
      else
        load_setup(pick_width(), pick_width(), $urandom_range(0, 60) - 40,
                   $urandom_range(30, 200), $urandom_range(0, 60) - 40,
                   $urandom_range(30, 200), mcor_pkg::orient_e'(phase % 4));
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end && items_sent < stop_at) random_circle();
      drain();
      phase++;
    end

    if (outline.mismatches == 0 && outline.pending() == 0) begin
      $display("midpoint_circle_outline_raster_core_test: PASS");
    end else begin
      $display("midpoint_circle_outline_raster_core_test: FAIL");
    end
    $finish;
  end

endmodule
